// File: rtl/telltale_lamp_fault_monitor_unit_assert.svh
// Assertion macros used by the lamp fault monitor top level
`ifndef TELLTALE_LAMP_FAULT_MONITOR_UNIT_ASSERT_SVH
`define TELLTALE_LAMP_FAULT_MONITOR_UNIT_ASSERT_SVH

// Same-cycle implication, checked on every rising clk edge outside reset
`define TLFM_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clk edge outside reset
`define TLFM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/tlfm_pkg.sv
// Types, constants and register codes of the lamp fault monitor
`default_nettype none

package tlfm_pkg;

    // Field widths
    localparam int ADC_W        = 16;
    localparam int SAMPLE_SHIFT = 5;
    localparam int SAMPLE_W     = ADC_W - SAMPLE_SHIFT;
    localparam int SETTLE_W     = 8;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 11;

    // Averaging window
    localparam int WINDOW_LEN  = 6;
    localparam int WIN_ADDR_W  = $clog2(WINDOW_LEN);
    localparam int IDX_W       = $clog2(WINDOW_LEN + 1);
    localparam int SUM_W       = SAMPLE_W + WIN_ADDR_W;

    // Divide by WINDOW_LEN: multiply by a rounded-up reciprocal, then shift
    localparam int DIV_SHIFT   = SUM_W + WIN_ADDR_W;
    localparam int RECIP_W     = SUM_W + 1;
    localparam int PROD_W      = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << DIV_SHIFT) + WINDOW_LEN - 1) / WINDOW_LEN);

    // Register reset values
    localparam logic [SAMPLE_W-1:0] OPEN_LEVEL_RST   = 11'd900;
    localparam logic [SAMPLE_W-1:0] NORMAL_LOW_RST   = 11'd418;
    localparam logic [SAMPLE_W-1:0] NORMAL_HIGH_RST  = 11'd776;
    localparam logic [SAMPLE_W-1:0] SHORT_LEVEL_RST  = 11'd108;
    localparam logic [SETTLE_W-1:0] SETTLE_TICKS_RST = 8'd5;

    // Register indexes of the config port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OPEN_LEVEL   = 3'd0,
        CFG_NORMAL_LOW   = 3'd1,
        CFG_NORMAL_HIGH  = 3'd2,
        CFG_SHORT_LEVEL  = 3'd3,
        CFG_SETTLE_TICKS = 3'd4
    } cfg_reg_e;

    // Fault codes
    typedef enum logic [1:0] {
        FAULT_NONE   = 2'd0,
        FAULT_OPEN   = 2'd1,
        FAULT_SHORT  = 2'd2,
        FAULT_COMMON = 2'd3
    } fault_e;

    typedef struct packed {
        logic [SAMPLE_W-1:0] open_level;
        logic [SAMPLE_W-1:0] normal_low;
        logic [SAMPLE_W-1:0] normal_high;
        logic [SAMPLE_W-1:0] short_level;
        logic [SETTLE_W-1:0] settle_ticks;
    } cfg_t;

    // One registered tick: lamp command and feedback sample
    typedef struct packed {
        logic                lamp_cmd;
        logic [SAMPLE_W-1:0] sample;
    } tick_t;

    typedef struct packed {
        logic                lamp_on;
        fault_e              lamp_fault;
        logic                diag_updated;
        logic [SAMPLE_W-1:0] average_level;
    } result_t;

endpackage

`default_nettype wire

// File: rtl/tlfm_cfg_regs.sv
// Threshold and settle registers behind the write-only config port
`default_nettype none

module tlfm_cfg_regs (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_write,
    input  wire logic [tlfm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [tlfm_pkg::CFG_DATA_W-1:0]  cfg_data,
    output tlfm_pkg::cfg_t                        cfg
);

    tlfm_pkg::cfg_t cfg_reg;
    tlfm_pkg::cfg_t cfg_next;

    // Index decode; unknown indexes are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                tlfm_pkg::CFG_OPEN_LEVEL:   cfg_next.open_level  = cfg_data;
                tlfm_pkg::CFG_NORMAL_LOW:   cfg_next.normal_low  = cfg_data;
                tlfm_pkg::CFG_NORMAL_HIGH:  cfg_next.normal_high = cfg_data;
                tlfm_pkg::CFG_SHORT_LEVEL:  cfg_next.short_level = cfg_data;
                tlfm_pkg::CFG_SETTLE_TICKS:
                    cfg_next.settle_ticks = cfg_data[tlfm_pkg::SETTLE_W-1:0];
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.open_level   <= tlfm_pkg::OPEN_LEVEL_RST;
            cfg_reg.normal_low   <= tlfm_pkg::NORMAL_LOW_RST;
            cfg_reg.normal_high  <= tlfm_pkg::NORMAL_HIGH_RST;
            cfg_reg.short_level  <= tlfm_pkg::SHORT_LEVEL_RST;
            cfg_reg.settle_ticks <= tlfm_pkg::SETTLE_TICKS_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// File: rtl/tlfm_in_stage.sv
// Input register: lamp decision and sample extraction for each transfer
`default_nettype none

module tlfm_in_stage (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic                          ignition_on,
    input  wire logic                          low_voltage_ok,
    input  wire logic                          high_voltage_ok,
    input  wire logic                          bus_off,
    input  wire logic                          message_missing,
    input  wire logic                          checksum_error,
    input  wire logic                          alive_error,
    input  wire logic                          sensor_fault,
    input  wire logic                          stand_down,
    input  wire logic [tlfm_pkg::ADC_W-1:0]    adc_raw,
    input  wire logic                          advance,
    output logic                               tick_valid,
    output tlfm_pkg::tick_t                    tick
);

    logic            valid_reg;
    logic            valid_next;
    tlfm_pkg::tick_t tick_reg;
    tlfm_pkg::tick_t tick_next;
    logic            accept;
    logic            supply_ok;
    logic            link_bad;

    // Lamp command: off without supply, else on with a bad link, a sensor fault or stand-down
    always_comb
    begin
        supply_ok = ignition_on & low_voltage_ok & high_voltage_ok;
        link_bad  = bus_off | message_missing | checksum_error | alive_error;
        tick_next.lamp_cmd = supply_ok & (link_bad | sensor_fault | stand_down);
        tick_next.sample   = adc_raw[tlfm_pkg::ADC_W-1:tlfm_pkg::SAMPLE_SHIFT];
    end

    // Hold only while the tick cannot move on
    assign in_stall   = valid_reg & ~advance;
    assign accept     = in_valid & ~in_stall;
    assign valid_next = accept | (valid_reg & ~advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            tick_reg <= tick_next;
        end
    end

    assign tick_valid = valid_reg;
    assign tick       = tick_reg;

endmodule

`default_nettype wire

// File: rtl/tlfm_diag_core.sv
// Settle countdown, sample window with running sum, averaging and judgement
`default_nettype none

module tlfm_diag_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        advance,
    input  tlfm_pkg::tick_t  tick,
    input  tlfm_pkg::cfg_t   cfg,
    output tlfm_pkg::result_t result
);

    localparam int W  = tlfm_pkg::WINDOW_LEN;
    localparam int SW = tlfm_pkg::SAMPLE_W;

    logic                              prev_lamp_reg;
    logic                              prev_lamp_next;
    logic [tlfm_pkg::SETTLE_W-1:0]     settle_reg;
    logic [tlfm_pkg::SETTLE_W-1:0]     settle_next;
    logic [tlfm_pkg::IDX_W-1:0]        index_reg;
    logic [tlfm_pkg::IDX_W-1:0]        index_next;
    logic [SW-1:0]                     window_reg [W];
    logic [SW-1:0]                     window_next [W];
    logic [tlfm_pkg::SUM_W-1:0]        sum_reg;
    logic [tlfm_pkg::SUM_W-1:0]        sum_next;
    logic [SW-1:0]                     average_reg;
    logic [SW-1:0]                     average_next;
    tlfm_pkg::fault_e                  fault_reg;
    tlfm_pkg::fault_e                  fault_next;

    logic                              changed;
    logic [tlfm_pkg::SETTLE_W-1:0]     settle_eff;
    logic [tlfm_pkg::IDX_W-1:0]        index_eff;
    logic [tlfm_pkg::WIN_ADDR_W-1:0]   addr;
    logic                              take;
    logic                              full;
    logic                              store;
    logic                              judged;
    logic [SW-1:0]                     old_sample;
    logic [tlfm_pkg::SUM_W-1:0]        sum_new;
    logic [tlfm_pkg::PROD_W-1:0]       product;
    logic [SW-1:0]                     average;
    tlfm_pkg::fault_e                  fault_judged;

    // Lamp change restarts the window and the countdown
    always_comb
    begin
        changed    = tick.lamp_cmd != prev_lamp_reg;
        settle_eff = changed ? cfg.settle_ticks : settle_reg;
        index_eff  = changed ? '0 : index_reg;
        addr       = index_eff[tlfm_pkg::WIN_ADDR_W-1:0];
        take       = settle_eff == '0;
        full       = index_eff >= tlfm_pkg::IDX_W'(W);
        store      = take & ~full;
        judged     = take & full;
    end

    // Running sum: the entry leaving is the oldest on a shift, else the overwritten one
    always_comb
    begin
        old_sample = full ? window_reg[0] : window_reg[addr];
        sum_new    = sum_reg + tlfm_pkg::SUM_W'(tick.sample)
                             - tlfm_pkg::SUM_W'(old_sample);
        product    = tlfm_pkg::PROD_W'(sum_new) * tlfm_pkg::PROD_W'(tlfm_pkg::RECIP);
        average    = product[tlfm_pkg::DIV_SHIFT +: SW];
    end

    // Threshold tests, in priority order, per lamp state
    always_comb
    begin
        fault_judged = fault_reg;
        if (tick.lamp_cmd)
        begin
            if (average >= cfg.open_level)
                fault_judged = tlfm_pkg::FAULT_OPEN;
            else if (average >= cfg.normal_low && average <= cfg.normal_high)
                fault_judged = tlfm_pkg::FAULT_NONE;
            else if (average <= cfg.short_level)
                fault_judged = tlfm_pkg::FAULT_SHORT;
        end
        else
        begin
            if (average >= cfg.open_level)
                fault_judged = tlfm_pkg::FAULT_NONE;
            else if (average >= cfg.normal_low)
                fault_judged = tlfm_pkg::FAULT_SHORT;
            else if (average == '0)
                fault_judged = tlfm_pkg::FAULT_COMMON;
        end
    end

    // Window fill or shift
    always_comb
    begin
        window_next = window_reg;
        if (judged)
        begin
            for (int i = 0; i < W - 1; i++)
            begin
                window_next[i] = window_reg[i + 1];
            end
            window_next[W - 1] = tick.sample;
        end
        else if (store)
        begin
            window_next[addr] = tick.sample;
        end
    end

    // Remaining next state
    always_comb
    begin
        prev_lamp_next = tick.lamp_cmd;
        settle_next    = take ? settle_eff : settle_eff - 1'b1;
        if (judged)
            index_next = '0;
        else if (store)
            index_next = index_eff + 1'b1;
        else
            index_next = index_eff;
        sum_next     = take ? sum_new : sum_reg;
        average_next = judged ? average : average_reg;
        fault_next   = judged ? fault_judged : fault_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_lamp_reg <= 1'b0;
            settle_reg    <= '0;
            index_reg     <= '0;
            for (int i = 0; i < W; i++)
            begin
                window_reg[i] <= '0;
            end
            sum_reg       <= '0;
            average_reg   <= '0;
            fault_reg     <= tlfm_pkg::FAULT_NONE;
        end
        else if (advance)
        begin
            prev_lamp_reg <= prev_lamp_next;
            settle_reg    <= settle_next;
            index_reg     <= index_next;
            window_reg    <= window_next;
            sum_reg       <= sum_next;
            average_reg   <= average_next;
            fault_reg     <= fault_next;
        end
    end

    // Result of the tick in flight
    always_comb
    begin
        result.lamp_on       = tick.lamp_cmd;
        result.lamp_fault    = fault_next;
        result.diag_updated  = judged;
        result.average_level = average_next;
    end

endmodule

`default_nettype wire

// File: rtl/tlfm_out_reg.sv
// Result register holding one finished tick until its transfer
`default_nettype none

module tlfm_out_reg (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         advance,
    input  tlfm_pkg::result_t result,
    input  wire logic         out_stall,
    output logic              out_valid,
    output tlfm_pkg::result_t out_result
);

    logic              valid_reg;
    logic              valid_next;
    tlfm_pkg::result_t result_reg;

    // Full after a load, until the downstream side takes it
    assign valid_next = advance | (valid_reg & out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule

`default_nettype wire

// File: rtl/telltale_lamp_fault_monitor_unit.sv
// Top level of the telltale lamp fault monitor
//
// One tick per clock while the output is not stalled: a transferred tick lands in
// the input register, is judged and loaded into the result register when it
// advances, and is offered on the output from then on until its result transfer.
// The input register and the result register each hold one tick, so in_stall
// rises only when both are full and the result is stalled; throughput is one tick
// per cycle while the output does not stall. The feedback average uses a running
// window sum and a reciprocal multiply, all in the single pass between the two
// registers. Config writes take effect once registered in the config registers.
`default_nettype none
`include "telltale_lamp_fault_monitor_unit_assert.svh"

module telltale_lamp_fault_monitor_unit (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // config port
    input  wire logic                              cfg_write,
    input  wire logic [tlfm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [tlfm_pkg::CFG_DATA_W-1:0]   cfg_data,
    // tick input
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic                              ignition_on,
    input  wire logic                              low_voltage_ok,
    input  wire logic                              high_voltage_ok,
    input  wire logic                              bus_off,
    input  wire logic                              message_missing,
    input  wire logic                              checksum_error,
    input  wire logic                              alive_error,
    input  wire logic                              sensor_fault,
    input  wire logic                              stand_down,
    input  wire logic [tlfm_pkg::ADC_W-1:0]        adc_raw,
    // result output
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic                                   lamp_on,
    output logic [1:0]                             lamp_fault,
    output logic                                   diag_updated,
    output logic [tlfm_pkg::SAMPLE_W-1:0]          average_level
);

    tlfm_pkg::cfg_t    cfg;
    tlfm_pkg::tick_t   tick;
    tlfm_pkg::result_t result;
    tlfm_pkg::result_t out_result;
    logic              tick_valid;
    logic              advance;

    // Tick moves on when the result register is free or being emptied
    assign advance = tick_valid & (~out_valid | ~out_stall);

    tlfm_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tlfm_in_stage u_in_stage (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .ignition_on     (ignition_on),
        .low_voltage_ok  (low_voltage_ok),
        .high_voltage_ok (high_voltage_ok),
        .bus_off         (bus_off),
        .message_missing (message_missing),
        .checksum_error  (checksum_error),
        .alive_error     (alive_error),
        .sensor_fault    (sensor_fault),
        .stand_down      (stand_down),
        .adc_raw         (adc_raw),
        .advance         (advance),
        .tick_valid      (tick_valid),
        .tick            (tick)
    );

    tlfm_diag_core u_diag_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .tick    (tick),
        .cfg     (cfg),
        .result  (result)
    );

    tlfm_out_reg u_out_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .result     (result),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .out_result (out_result)
    );

    // Result fields to ports
    assign lamp_on       = out_result.lamp_on;
    assign lamp_fault    = out_result.lamp_fault;
    assign diag_updated  = out_result.diag_updated;
    assign average_level = out_result.average_level;

    // Checks
    `TLFM_ASSERT_IMPLY(a_no_stall_when_out_empty, !out_valid, !in_stall,
        "input stalled while result register is empty")
    `TLFM_ASSERT_NEXT(a_advance_fills_out, advance, out_valid,
        "advanced tick did not reach the result register")
    `TLFM_ASSERT_IMPLY(a_off_zero_is_common,
        out_valid && diag_updated && !lamp_on && average_level == '0
            && cfg.open_level != '0 && cfg.normal_low != '0,
        lamp_fault == tlfm_pkg::FAULT_COMMON,
        "zero average with lamp off not flagged as common error")
    `TLFM_ASSERT_IMPLY(a_on_high_is_open,
        out_valid && diag_updated && lamp_on && average_level >= cfg.open_level,
        lamp_fault == tlfm_pkg::FAULT_OPEN,
        "high average with lamp on not flagged as open")

endmodule

`default_nettype wire
